[hdl/mcr_pkg.sv]
`default_nettype none

package mcr_pkg;

    localparam int unsigned COORD_W   = 12;
    localparam int unsigned RAD_W     = 11;
    localparam int unsigned POS_W     = 13;
    localparam int unsigned DIM_W     = 13;
    localparam int unsigned DEC_W     = 16;
    localparam int unsigned ADDR_W    = 25;
    localparam int unsigned COLOR_W   = 32;
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned STEP_IDX_W = 3;

    localparam int unsigned MCR_MAX_DIM = 4096;

    // Midpoint decision constants
    localparam logic [DEC_W-1:0] DEC_INIT = 16'd3;
    localparam logic [DEC_W-1:0] DEC_DIAG = 16'd10;
    localparam logic [DEC_W-1:0] DEC_AXIS = 16'd6;

    localparam int unsigned ALPHA_LSB = 24;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic FMT_ARGB32 = 1'b0;
    localparam logic FMT_RGB24  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 2'd2;

    // One octant step handed from the stepper to the emitter
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               fill;
        logic               done;
        logic               rejected;
    } rec_t;

endpackage

`default_nettype wire

[hdl/mcr_step.sv]
`default_nettype none

module mcr_step (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           accept,
    input  wire                           command,
    input  wire  [mcr_pkg::COORD_W-1:0]   center_x,
    input  wire  [mcr_pkg::COORD_W-1:0]   center_y,
    input  wire  [mcr_pkg::RAD_W-1:0]     radius,
    input  wire  [mcr_pkg::CHAN_W-1:0]    alpha,
    input  wire  [mcr_pkg::CHAN_W-1:0]    red,
    input  wire  [mcr_pkg::CHAN_W-1:0]    green,
    input  wire  [mcr_pkg::CHAN_W-1:0]    blue,
    input  wire                           fill_mode,
    input  wire  [mcr_pkg::DIM_W-1:0]     width_eff,
    input  wire  [mcr_pkg::DIM_W-1:0]     height_eff,
    output mcr_pkg::rec_t                 rec
);

    import mcr_pkg::*;

    logic [COORD_W-1:0] step_x_reg, step_x_next;
    logic [COORD_W-1:0] step_y_reg, step_y_next;
    logic [DEC_W-1:0]   decision_reg, decision_next;
    logic [COORD_W-1:0] held_cx_reg, held_cx_next;
    logic [COORD_W-1:0] held_cy_reg, held_cy_next;
    logic [COLOR_W-1:0] held_color_reg, held_color_next;
    logic               held_fill_reg, held_fill_next;
    logic               active_reg, active_next;

    logic [DIM_W-1:0]   xc_ext, yc_ext, r_ext;
    logic [DIM_W-1:0]   x_plus_r, y_plus_r;
    logic               clip_fail;
    logic [COORD_W-1:0] x1, y1;
    logic [DEC_W-1:0]   d1;
    logic [COLOR_W-1:0] color_in;

    always_comb
    begin
        xc_ext    = {1'b0, center_x};
        yc_ext    = {1'b0, center_y};
        r_ext     = {2'b00, radius};
        x_plus_r  = xc_ext + r_ext;
        y_plus_r  = yc_ext + r_ext;
        clip_fail = (x_plus_r > width_eff) || (xc_ext < r_ext) ||
                    (y_plus_r > height_eff) || (yc_ext < r_ext);
        color_in  = {alpha, red, green, blue};

        x1 = step_x_reg + 1'b1;
        if (!decision_reg[DEC_W-1])
        begin
            y1 = step_y_reg - 1'b1;
            d1 = decision_reg + ((({4'b0000, x1} - {4'b0000, y1})) << 2) + DEC_DIAG;
        end
        else
        begin
            y1 = step_y_reg;
            d1 = decision_reg + ({4'b0000, x1} << 2) + DEC_AXIS;
        end

        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        decision_next   = decision_reg;
        held_cx_next    = held_cx_reg;
        held_cy_next    = held_cy_reg;
        held_color_next = held_color_reg;
        held_fill_next  = held_fill_reg;
        active_next     = active_reg;

        rec          = '0;
        rec.done     = 1'b1;
        rec.rejected = 1'b1;

        if (command == CMD_START)
        begin
            if (!clip_fail)
            begin
                step_x_next     = '0;
                step_y_next     = {1'b0, radius};
                decision_next   = DEC_INIT - ({5'b00000, radius} << 1);
                held_cx_next    = center_x;
                held_cy_next    = center_y;
                held_color_next = color_in;
                held_fill_next  = fill_mode;
                active_next     = (radius != '0);
                rec.cx       = center_x;
                rec.cy       = center_y;
                rec.x        = '0;
                rec.y        = {1'b0, radius};
                rec.color    = color_in;
                rec.fill     = fill_mode;
                rec.done     = (radius == '0);
                rec.rejected = 1'b0;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
        else if (active_reg)
        begin
            step_x_next   = x1;
            step_y_next   = y1;
            decision_next = d1;
            active_next   = !(y1 < x1);
            rec.cx       = held_cx_reg;
            rec.cy       = held_cy_reg;
            rec.x        = x1;
            rec.y        = y1;
            rec.color    = held_color_reg;
            rec.fill     = held_fill_reg;
            rec.done     = (y1 < x1);
            rec.rejected = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            decision_reg   <= '0;
            held_cx_reg    <= '0;
            held_cy_reg    <= '0;
            held_color_reg <= '0;
            held_fill_reg  <= 1'b0;
            active_reg     <= 1'b0;
        end
        else if (accept)
        begin
            step_x_reg     <= step_x_next;
            step_y_reg     <= step_y_next;
            decision_reg   <= decision_next;
            held_cx_reg    <= held_cx_next;
            held_cy_reg    <= held_cy_next;
            held_color_reg <= held_color_next;
            held_fill_reg  <= held_fill_next;
            active_reg     <= active_next;
        end
    end

    // An active circle never has y below x
    a_active_octant: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> !(step_y_reg < step_x_reg))
        else $error("active circle past the octant end");

    a_reject_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rec.rejected |=> !active_reg)
        else $error("circle still active after a rejected beat");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rec.done |=> !active_reg)
        else $error("circle still active after its last step");

endmodule

`default_nettype wire

[hdl/mcr_emit.sv]
`default_nettype none

module mcr_emit (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            accept,
    input  wire  mcr_pkg::rec_t            rec_in,
    input  wire  [mcr_pkg::DIM_W-1:0]      width_eff,
    input  wire  [mcr_pkg::DIM_W-1:0]      height_eff,
    input  wire                            pixel_fmt,
    input  wire                            out_stall,
    output logic                           busy,
    output logic                           out_valid,
    output logic [mcr_pkg::POS_W-1:0]      pos_x,
    output logic [mcr_pkg::POS_W-1:0]      pos_y,
    output logic [mcr_pkg::ADDR_W-1:0]     pixel_address,
    output logic [mcr_pkg::POS_W-1:0]      run_length,
    output logic [mcr_pkg::COLOR_W-1:0]    color_word,
    output logic                           last_in_step,
    output logic                           circle_done,
    output logic                           rejected
);

    import mcr_pkg::*;

    rec_t                  rec_reg;
    logic                  rec_valid_reg, rec_valid_next;
    logic [STEP_IDX_W-1:0] idx_reg, idx_next;

    logic                  out_valid_reg, out_valid_next;
    logic [POS_W-1:0]      pos_x_reg, pos_y_reg, run_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic                  last_reg, done_reg, rej_reg;

    logic                  load;
    logic                  is_last;
    logic [STEP_IDX_W-1:0] oct;
    logic [COORD_W-1:0]    off_h, off_v;
    logic [POS_W-1:0]      px, py, span, span_run, run_sel;
    logic [POS_W:0]        span_end;
    logic [2*POS_W-1:0]    row_base;
    logic [ADDR_W-1:0]     addr_sel;
    logic [COLOR_W-1:0]    color_sel;

    always_comb
    begin
        is_last = rec_reg.rejected ||
                  (rec_reg.fill ? (idx_reg[1:0] == 2'b11) : (idx_reg == 3'b111));
        load    = rec_valid_reg && (!out_valid_reg || !out_stall);
        busy    = rec_valid_reg && !(load && is_last);

        // A fill span sits on the odd (left-hand) octant positions
        oct   = rec_reg.fill ? {idx_reg[1:0], 1'b1} : idx_reg;
        off_h = oct[2] ? rec_reg.y : rec_reg.x;
        off_v = oct[2] ? rec_reg.x : rec_reg.y;
        px    = oct[0] ? ({1'b0, rec_reg.cx} - {1'b0, off_h})
                       : ({1'b0, rec_reg.cx} + {1'b0, off_h});
        py    = oct[1] ? ({1'b0, rec_reg.cy} - {1'b0, off_v})
                       : ({1'b0, rec_reg.cy} + {1'b0, off_v});

        span     = {off_h, 1'b0};
        span_end = {1'b0, px} + {1'b0, span};
        if ((px >= width_eff) || (py >= height_eff) || (span == '0))
            span_run = '0;
        else if (span_end > {1'b0, width_eff})
            span_run = width_eff - px;
        else
            span_run = span;
        run_sel = rec_reg.fill ? span_run : POS_W'(1);

        row_base  = py * width_eff;
        addr_sel  = row_base[ADDR_W-1:0] + {{(ADDR_W-POS_W){1'b0}}, px};
        color_sel = (pixel_fmt == FMT_RGB24)
                    ? {{(COLOR_W-ALPHA_LSB){1'b0}}, rec_reg.color[ALPHA_LSB-1:0]}
                    : rec_reg.color;

        if (accept)
            rec_valid_next = 1'b1;
        else if (load && is_last)
            rec_valid_next = 1'b0;
        else
            rec_valid_next = rec_valid_reg;

        if (accept)
            idx_next = '0;
        else if (load)
            idx_next = idx_reg + 1'b1;
        else
            idx_next = idx_reg;

        if (load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rec_reg <= rec_in;
        if (load)
        begin
            if (rec_reg.rejected)
            begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                addr_reg  <= '0;
                run_reg   <= '0;
                color_reg <= '0;
            end
            else
            begin
                pos_x_reg <= px;
                pos_y_reg <= py;
                addr_reg  <= addr_sel;
                run_reg   <= run_sel;
                color_reg <= color_sel;
            end
            last_reg <= is_last;
            done_reg <= rec_reg.done;
            rej_reg  <= rec_reg.rejected;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign pixel_address = addr_reg;
    assign run_length    = run_reg;
    assign color_word    = color_reg;
    assign last_in_step  = last_reg;
    assign circle_done   = done_reg;
    assign rejected      = rej_reg;

    a_fill_four: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid_reg && rec_reg.fill && !rec_reg.rejected |-> !idx_reg[2])
        else $error("fill step past its fourth span");

    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rej_reg |-> last_reg && done_reg)
        else $error("rejected beat not marked last and done");

    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        load && is_last && !accept |=> !rec_valid_reg)
        else $error("step record held after its last beat");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !rec_valid_reg || (load && is_last))
        else $error("new step taken over a pending one");

endmodule

`default_nettype wire

[hdl/midpoint_circle_rasterizer_top.sv]
`default_nettype none

// Midpoint circle rasterizer.
// Command beats come in on in_valid/in_stall. A start beat latches center, radius,
// color and mode, runs the canvas clip check and yields the first octant step; each
// advance beat yields the next step. Result beats leave on out_valid/out_stall.
// A stroke step gives 8 pixel beats, a fill step 4 span beats, a rejected start or
// an advance with no circle in progress 1 beat. last_in_step marks the final beat of
// a command, circle_done the beats of the last step.
// The first result beat of a command passes through the step record register and then the
// result register. Throughput: one result beat per cycle while out_stall is low; a command
// holds the single result register for all its beats, which also caps command intake; the next
// command is taken in the cycle its predecessor's last beat is loaded.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no command is in flight.
// Reset clears the active circle and restores width 640, height 480, ARGB32.
// While out_stall is high the output beat holds. in_stall is high while a step's beats are
// still being emitted and drops in the cycle its last beat is loaded.

module midpoint_circle_rasterizer_top #(
    parameter int unsigned MAX_DIM = mcr_pkg::MCR_MAX_DIM
) (
    input  wire                              clk,
    input  wire                              rst_n,

    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [mcr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [mcr_pkg::DIM_W-1:0]        cfg_data,

    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire                              command,
    input  wire  [mcr_pkg::COORD_W-1:0]      center_x,
    input  wire  [mcr_pkg::COORD_W-1:0]      center_y,
    input  wire  [mcr_pkg::RAD_W-1:0]        radius,
    input  wire  [mcr_pkg::CHAN_W-1:0]       alpha,
    input  wire  [mcr_pkg::CHAN_W-1:0]       red,
    input  wire  [mcr_pkg::CHAN_W-1:0]       green,
    input  wire  [mcr_pkg::CHAN_W-1:0]       blue,
    input  wire                              fill_mode,

    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [mcr_pkg::POS_W-1:0]        pos_x,
    output logic [mcr_pkg::POS_W-1:0]        pos_y,
    output logic [mcr_pkg::ADDR_W-1:0]       pixel_address,
    output logic [mcr_pkg::POS_W-1:0]        run_length,
    output logic [mcr_pkg::COLOR_W-1:0]      color_word,
    output logic                             last_in_step,
    output logic                             circle_done,
    output logic                             rejected
);

    import mcr_pkg::*;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic             fmt_reg;
    logic [DIM_W-1:0] width_eff, height_eff;
    logic             accept;
    logic             busy;
    rec_t             rec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
            fmt_reg    <= FMT_ARGB32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CANVAS_WIDTH:  width_reg  <= cfg_data;
                REG_CANVAS_HEIGHT: height_reg <= cfg_data;
                REG_PIXEL_FORMAT:  fmt_reg    <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Clamp oversized dimensions
    always_comb
    begin
        width_eff  = (32'(width_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : width_reg;
        height_eff = (32'(height_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : height_reg;
    end

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    mcr_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (command),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .alpha      (alpha),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .fill_mode  (fill_mode),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .rec        (rec)
    );

    mcr_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rec_in        (rec),
        .width_eff     (width_eff),
        .height_eff    (height_eff),
        .pixel_fmt     (fmt_reg),
        .out_stall     (out_stall),
        .busy          (busy),
        .out_valid     (out_valid),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pixel_address (pixel_address),
        .run_length    (run_length),
        .color_word    (color_word),
        .last_in_step  (last_in_step),
        .circle_done   (circle_done),
        .rejected      (rejected)
    );

endmodule

`default_nettype wire
